// ----- sv/sidta_pkg.sv -----
package sidta_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Double-dabble correction: a BCD digit of five or more gets three added
   // before the shift so that it carries into the next digit.
   localparam logic [3:0] DD_THRESH = 4'd5;
   localparam logic [3:0] DD_ADJ    = 4'd3;

   // Shift-and-adjust steps done in one pipeline stage.
   localparam int STEPS_PER_STAGE = 4;

   typedef struct packed {
      logic valid;
      logic neg;
   } sidta_ctl_type;

endpackage

// ----- sv/signed_int_to_decimal_ascii_top.sv -----
// Converts one signed two's-complement value per input word into its decimal
// text, sent as one ASCII character per output word, most significant first,
// with tlast on the final character. Negative values get a leading minus
// sign, and leading spaces pad the text up to the minimum width written on
// the csr port (values above MAX_WIDTH saturate to MAX_WIDTH). The binary to
// BCD conversion is a double-dabble pipeline of VALUE_BITS/4 stages, rounded
// up (four shift steps each, fewer in the last), followed by a digit-count stage
// and the character serializer. The serializer sends one character per cycle
// while rsp_tready does not hold it back, so a value sends max(text length,
// minimum width) characters: up to eleven for an unpadded 32-bit value. The
// pipeline takes a new value in every cycle while it has room and stalls as a
// whole when the serializer is still busy.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_WIDTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: value (VALUE_BITS bits, signed), zero fill to bytes.
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: ascii_char (8 bits).
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   // Fields from bit 0: min_width (6 bits).
   input  logic [5:0]                        csr_data
);
   import sidta_pkg::*;

   // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
   localparam int DIGITS  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W   = DIGITS * 4;
   localparam int NSTAGE  = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int LEN_MAX = (MAX_WIDTH > DIGITS + 1) ? MAX_WIDTH : DIGITS + 1;
   localparam int CNT_W   = $clog2(LEN_MAX + 1);

   logic                    en, ser_ready;
   logic [VALUE_BITS-1:0]   raw;
   logic [CNT_W-1:0]        min_width_ff, min_width_in;

   sidta_ctl_type           dd_ctl [NSTAGE+1];
   logic [BCD_W-1:0]        dd_bcd [NSTAGE+1];
   logic [VALUE_BITS-1:0]   dd_bin [NSTAGE+1];

   sidta_ctl_type           in_ctl_ff;
   logic [VALUE_BITS-1:0]   in_mag_ff;

   sidta_ctl_type           lead_ctl_ff;
   logic [BCD_W-1:0]        lead_bcd_ff;
   logic [CNT_W-1:0]        lead_len_ff, lead_len_in;

   // The whole pipeline advances together unless its last stage is stuck.
   assign en         = !lead_ctl_ff.valid || ser_ready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   assign raw          = req_tdata[VALUE_BITS-1:0];
   assign min_width_in = (int'(csr_data) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(csr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff    <= '0;
         in_ctl_ff.valid <= 1'b0;
         lead_ctl_ff.valid <= 1'b0;
      end else begin
         if (csr_valid) begin
            min_width_ff <= min_width_in;
         end
         if (en) begin
            in_ctl_ff.valid   <= req_tvalid;
            lead_ctl_ff.valid <= dd_ctl[NSTAGE].valid;
         end
      end
      if (en) begin
         // Two's-complement negate gives the right magnitude even for the
         // most negative value when read as unsigned.
         in_ctl_ff.neg   <= raw[VALUE_BITS-1];
         in_mag_ff       <= raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
         lead_ctl_ff.neg <= dd_ctl[NSTAGE].neg;
         lead_bcd_ff     <= dd_bcd[NSTAGE];
         lead_len_ff     <= lead_len_in;
      end
   end

   assign dd_ctl[0] = in_ctl_ff;
   assign dd_bcd[0] = '0;
   assign dd_bin[0] = in_mag_ff;

   for (genvar s = 0; s < NSTAGE; s++) begin : g_dd
      localparam int LEFT  = VALUE_BITS - s * STEPS_PER_STAGE;
      localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;
      sidta_dd_stage #(
         .VALUE_BITS (VALUE_BITS),
         .BCD_W      (BCD_W),
         .STEPS      (STEPS)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (dd_ctl[s]),
         .bcd_i (dd_bcd[s]),
         .bin_i (dd_bin[s]),
         .ctl_o (dd_ctl[s+1]),
         .bcd_o (dd_bcd[s+1]),
         .bin_o (dd_bin[s+1])
      );
   end

   // Text length: significant digits (at least one) plus the sign.
   always_comb begin
      logic [CNT_W-1:0] nd;
      nd = CNT_W'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (dd_bcd[NSTAGE][i*4 +: 4] != 4'd0) begin
            nd = CNT_W'(i + 1);
         end
      end
      lead_len_in = nd + CNT_W'(dd_ctl[NSTAGE].neg);
   end

   sidta_serial #(
      .DIGITS (DIGITS),
      .CNT_W  (CNT_W)
   ) u_serial (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (lead_ctl_ff),
      .bcd_i       (lead_bcd_ff),
      .len_i       (lead_len_ff),
      .min_width_i (min_width_ff),
      .ready_o     (ser_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- sv/sidta_dd_stage.sv -----
module sidta_dd_stage #(
   parameter int VALUE_BITS = 32,
   parameter int BCD_W      = 40,
   parameter int STEPS      = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  sidta_pkg::sidta_ctl_type ctl_i,
   input  logic [BCD_W-1:0]        bcd_i,
   input  logic [VALUE_BITS-1:0]   bin_i,
   output sidta_pkg::sidta_ctl_type ctl_o,
   output logic [BCD_W-1:0]        bcd_o,
   output logic [VALUE_BITS-1:0]   bin_o
);
   import sidta_pkg::*;

   localparam int NDIG = BCD_W / 4;

   sidta_ctl_type           ctl_ff;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;

   always_comb begin
      bcd_in = bcd_i;
      bin_in = bin_i;
      for (int k = 0; k < STEPS; k++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_in[d*4 +: 4] >= DD_THRESH) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + DD_ADJ;
            end
         end
         bcd_in = {bcd_in[BCD_W-2:0], bin_in[VALUE_BITS-1]};
         bin_in = {bin_in[VALUE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
      if (en) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign bcd_o = bcd_ff;
   assign bin_o = bin_ff;

endmodule

// ----- sv/sidta_serial.sv -----
module sidta_serial #(
   parameter int DIGITS = 10,
   parameter int CNT_W  = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sidta_pkg::sidta_ctl_type ctl_i,
   input  logic [DIGITS*4-1:0]      bcd_i,
   input  logic [CNT_W-1:0]         len_i,
   input  logic [CNT_W-1:0]         min_width_i,
   output logic                     ready_o,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);
   import sidta_pkg::*;

   localparam int DIG_IW = $clog2(DIGITS);

   logic                 busy_ff;
   logic [CNT_W-1:0]     pos_ff, total_ff, len_ff;
   logic                 neg_ff;
   logic [DIGITS*4-1:0]  digits_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff, char_in;
   logic                 rsp_last_ff;

   logic                 issue, at_end, load;
   logic [CNT_W-1:0]     pad, rev, total_in;
   logic [DIG_IW-1:0]    idx;

   assign issue    = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign at_end   = (pos_ff == total_ff - CNT_W'(1));
   assign ready_o  = !busy_ff || (issue && at_end);
   assign load     = ctl_i.valid && ready_o;
   assign total_in = (min_width_i > len_i) ? min_width_i : len_i;

   assign pad = total_ff - len_ff;
   assign rev = total_ff - CNT_W'(1) - pos_ff;
   assign idx = rev[DIG_IW-1:0];

   always_comb begin
      if (pos_ff < pad) begin
         char_in = CH_SPACE;
      end else if (neg_ff && (pos_ff == pad)) begin
         char_in = CH_MINUS;
      end else begin
         char_in = CH_ZERO | {4'd0, digits_ff[idx*4 +: 4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (issue && at_end) begin
            busy_ff <= 1'b0;
         end
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         pos_ff    <= '0;
         total_ff  <= total_in;
         len_ff    <= len_i;
         neg_ff    <= ctl_i.neg;
         digits_ff <= bcd_i;
      end else if (issue) begin
         pos_ff <= pos_ff + CNT_W'(1);
      end
      if (issue) begin
         rsp_data_ff <= char_in;
         rsp_last_ff <= at_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < total_ff))
      else $error("character position beyond text length");

   a_total_covers_text: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (total_ff >= len_ff))
      else $error("field width shorter than text");

   a_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (issue && !at_end) |=> busy_ff)
      else $error("serializer dropped a value before its last character");

endmodule

// ----- tb/signed_int_to_decimal_ascii_top_tb.sv -----
module signed_int_to_decimal_ascii_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sidta_pkg::*;

   localparam int VALUE_BITS      = 32;
   localparam int MAX_WIDTH       = 32;
   localparam int VALUES_PER_PASS = 35;
   localparam int SETTLE_CYCLES   = 24;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DIRECTED_ROWS   = 16;

   typedef struct {
      logic [7:0] ascii;
      logic       last;
   } text_char_type;

   // An empty text means the row is checked against the predictor.
   typedef struct {
      logic [31:0] value;
      string       text;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   text_char_type pending_chars[$];
   int unsigned   field_width = 0;
   int            mismatches = 0;
   int            idle_cycles = 0;
   bit            req_gaps = 1'b1;
   bit            rsp_stalls = 1'b1;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'd0,               "0"},
      '{32'd1,               "1"},
      '{-32'd1,              "-1"},
      '{32'd9,               "9"},
      '{32'd10,              "10"},
      '{-32'd10,             "-10"},
      '{-32'd7,              "-7"},
      '{32'h7FFF_FFFF,       "2147483647"},
      '{32'h8000_0000,       "-2147483648"},
      '{32'h8000_0001,       "-2147483647"},
      '{32'd1000000000,      "1000000000"},
      '{32'd999999999,       ""},
      '{-32'd1000000000,     ""},
      '{32'h5555_5555,       ""},
      '{32'hAAAA_AAAA,       ""},
      '{32'd12345,           ""}
   };

   signed_int_to_decimal_ascii_top #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_WIDTH (MAX_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Builds the padded decimal text of one value and queues its characters.
   function automatic void predict_text(logic [31:0] value);
      logic [7:0]  digits[$];
      logic [31:0] magnitude;
      logic        negative;
      int          text_len;
      negative  = value[VALUE_BITS-1];
      // The most negative value stays 0x80000000, read as unsigned.
      magnitude = negative ? (~value + 32'd1) : value;
      do begin
         digits.push_front(CH_ZERO + 8'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      text_len = digits.size() + (negative ? 1 : 0);
      for (int i = text_len; i < int'(field_width); i++) begin
         pending_chars.push_back('{CH_SPACE, 1'b0});
      end
      if (negative) begin
         pending_chars.push_back('{CH_MINUS, 1'b0});
      end
      foreach (digits[i]) begin
         pending_chars.push_back('{digits[i], 1'b0});
      end
      pending_chars[pending_chars.size()-1].last = 1'b1;
   endfunction

   function automatic void queue_typed_text(string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
      end
   endfunction

   // Mostly values near the digit-count boundaries, small ones and extremes.
   function automatic logic [31:0] random_value();
      logic [31:0]     magnitude;
      longint unsigned power;
      int              exponent;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: magnitude = $urandom_range(0, 99);
         2: begin
            exponent = $urandom_range(0, 9);
            power = 1;
            repeat (exponent) power = power * 10;
            magnitude = 32'(power - 1 + $urandom_range(0, 2));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               default: return 32'h8000_0001;
            endcase
         end
      endcase
      return $urandom_range(0, 1) ? -magnitude : magnitude;
   endfunction

   task automatic send_value(logic [31:0] value, string text);
      int gap;
      gap = req_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (text.len() == 0) begin
         predict_text(value);
      end else begin
         queue_typed_text(text);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_width(logic [5:0] width);
      csr_valid <= 1'b1;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      field_width = (width > MAX_WIDTH) ? MAX_WIDTH : width;
   endtask

   initial begin
      logic [5:0] pass_widths [8];
      pass_widths = '{6'd32, 6'd63, 6'd11, 6'd12, 6'd1, 6'd0, 6'd0, 6'd0};
      pass_widths[6] = 6'($urandom_range(0, 63));
      pass_widths[7] = 6'($urandom_range(2, 20));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the width left at its reset value.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_value(directed_rows[i].value, directed_rows[i].text);
      end

      for (int pass = 0; pass < 8; pass++) begin
         wait_for_drain();
         write_width(pass_widths[pass]);
         req_gaps   = (pass % 3) != 1;
         rsp_stalls = (pass % 3) != 2;
         for (int n = 0; n < VALUES_PER_PASS; n++) begin
            if (n == VALUES_PER_PASS / 2) begin
               wait_for_drain();
            end
            send_value(random_value(), "");
         end
      end

      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      text_char_type wanted;
      int            stall;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_stalls ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_chars.size() == 0) begin
            $error("unexpected word: ascii_char %h last_char %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            wanted = pending_chars.pop_front();
            if (rsp_tdata !== wanted.ascii) begin
               $error("ascii_char: expected %h, got %h", wanted.ascii, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== wanted.last) begin
               $error("last_char: expected %b, got %b", wanted.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
